[sv/cotr_pkg.sv]
// shared types, constants and sizing for the clock offset / trimmed rtt estimator
// no dependencies; every other file of the block refers to this package by scoped names
`default_nettype none

package cotr_pkg;

    // window of rtt samples: the current one plus the ring of earlier ones
    localparam int WINDOW_SIZE = 10;
    localparam int RING_DEPTH  = WINDOW_SIZE - 1;
    localparam int TRIM_COUNT  = WINDOW_SIZE - 2;

    localparam int TIME_W   = 40;
    localparam int OFFSET_W = TIME_W + 1;
    localparam int RTT_W    = 24;
    localparam logic [RTT_W-1:0] RTT_MAX = {RTT_W{1'b1}};

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    // sum of a full window
    localparam int SUM_W = RTT_W + $clog2(WINDOW_SIZE);

    // trimmed mean by reciprocal: floor(x / d) = (x * ceil(2^s / d)) >> s
    // with s = SUM_W + clog2(d), exact for every SUM_W-bit x
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIM_COUNT);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TRIM_COUNT) - 64'd1) / 64'(TRIM_COUNT));

    // min / max / sum reduction tree over the window
    localparam int TREE_LEVELS = $clog2(WINDOW_SIZE);
    localparam int TREE_NODES  = 1 << TREE_LEVELS;

    // registers between request acceptance and response
    localparam int PIPE_DEPTH = 5;

    typedef struct packed {
        logic [TIME_W-1:0] client_send_time;
        logic [TIME_W-1:0] server_reply_time;
        logic [TIME_W-1:0] arrival_time;
    } req_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] clock_offset;
        logic [RTT_W-1:0]           used_rtt;
        logic                       window_full;
    } rsp_t;

    // window statistics handed from the ring stage to the trim stage
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [RTT_W-1:0] lo;
        logic [RTT_W-1:0] hi;
        logic             full;
    } stats_t;

endpackage

`default_nettype wire

[sv/clock_offset_trimmed_rtt.sv]
// clock offset estimator with trimmed-mean round-trip time, top level
// depends on cotr_pkg, cotr_rtt_form, cotr_window, cotr_trim, cotr_offset
//
// Each request beat is one time-sync reply (client send, server reply and
// local arrival tick counts); each produces exactly one response beat with
// the clock offset (server - client - used_rtt/2, modulo 2^41), the rtt that
// was used and a flag for a full window. The rtt is arrival - send, clamped
// to 0..2^24-1. The first nine replies use their raw rtt; from the tenth on,
// the rtt is the mean of the current and the nine previous rtts with one
// minimum and one maximum dropped, rounded down. The block is a five-register
// pipeline (input, rtt, window statistics, trimmed mean, response) and takes
// one request per cycle unless stalled; a request passes them in order.
// The rtt ring is read and written in the statistics stage, one item per cycle
// as that stage advances, so back-to-back replies always see every earlier
// sample. Each stage moves on when the one after it is empty or moving, so
// bubbles are absorbed while a response waits under stall. req_stall therefore
// follows rsp_stall through the pipeline. No clearing pass after reset: the
// fill count alone decides when the window is full.
`default_nettype none

module clock_offset_trimmed_rtt (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   req_valid,
    output logic                  req_stall,
    input  wire cotr_pkg::req_t   req,
    output logic                  rsp_valid,
    input  wire                   rsp_stall,
    output cotr_pkg::rsp_t        rsp
);

    localparam int OffW = cotr_pkg::OFFSET_W;
    localparam int RttW = cotr_pkg::RTT_W;

    // stage valids
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic rsp_valid_reg;

    // stage payloads
    cotr_pkg::req_t   s1_req_reg;
    logic [OffW-1:0]  s2_diff_reg;
    logic [RttW-1:0]  s2_rtt_reg;
    logic [OffW-1:0]  s3_diff_reg;
    logic [RttW-1:0]  s3_rtt_reg;
    cotr_pkg::stats_t s3_stats_reg;
    logic [OffW-1:0]  s4_diff_reg;
    logic [RttW-1:0]  s4_rtt_reg;
    logic [RttW-1:0]  s4_mean_reg;
    logic             s4_full_reg;
    cotr_pkg::rsp_t   rsp_reg;

    // combinational results
    logic [OffW-1:0]  diff_next;
    logic [RttW-1:0]  rtt_next;
    cotr_pkg::stats_t stats_next;
    logic [RttW-1:0]  mean_next;
    cotr_pkg::rsp_t   rsp_next;

    // a stage may load when it is empty or its contents move on
    logic out_free;
    logic s4_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign req_stall = !s1_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && req_valid)
        begin
            s1_req_reg <= req;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_diff_reg <= diff_next;
            s2_rtt_reg  <= rtt_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_diff_reg  <= s2_diff_reg;
            s3_rtt_reg   <= s2_rtt_reg;
            s3_stats_reg <= stats_next;
        end
        if (s4_free && s3_valid_reg)
        begin
            s4_diff_reg <= s3_diff_reg;
            s4_rtt_reg  <= s3_rtt_reg;
            s4_mean_reg <= mean_next;
            s4_full_reg <= s3_stats_reg.full;
        end
        if (out_free && s4_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // stage 1: rtt and server - client
    cotr_rtt_form u_rtt_form (
        .req  (s1_req_reg),
        .diff (diff_next),
        .rtt  (rtt_next)
    );

    // stage 2: ring update as the beat leaves, statistics over the window
    cotr_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s2_valid_reg && s3_free),
        .rtt     (s2_rtt_reg),
        .stats   (stats_next)
    );

    // stage 3: trimmed mean
    cotr_trim u_trim (
        .stats (s3_stats_reg),
        .mean  (mean_next)
    );

    // stage 4: used rtt and offset
    cotr_offset u_offset (
        .diff (s4_diff_reg),
        .rtt  (s4_rtt_reg),
        .mean (s4_mean_reg),
        .full (s4_full_reg),
        .rsp  (rsp_next)
    );

endmodule

`default_nettype wire

[sv/cotr_rtt_form.sv]
// round-trip time and raw server-minus-client difference of one reply
// depends on cotr_pkg
`default_nettype none

module cotr_rtt_form (
    input  wire cotr_pkg::req_t                     req,
    output logic [cotr_pkg::OFFSET_W-1:0]           diff,
    output logic [cotr_pkg::RTT_W-1:0]              rtt
);

    localparam int OffW  = cotr_pkg::OFFSET_W;
    localparam int TimeW = cotr_pkg::TIME_W;
    localparam int RttW  = cotr_pkg::RTT_W;

    logic [OffW-1:0] span;

    always_comb
    begin
        diff = {1'b0, req.server_reply_time} - {1'b0, req.client_send_time};
        span = {1'b0, req.arrival_time} - {1'b0, req.client_send_time};
        if (span[OffW-1])
        begin
            // arrival before send
            rtt = '0;
        end
        else if (span[TimeW-1:RttW] != '0)
        begin
            rtt = cotr_pkg::RTT_MAX;
        end
        else
        begin
            rtt = span[RttW-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/cotr_window.sv]
// rtt ring, fill count and oldest pointer, plus min / max / sum tree over the window
// depends on cotr_pkg
`default_nettype none

module cotr_window (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              advance,
    input  wire [cotr_pkg::RTT_W-1:0]        rtt,
    output cotr_pkg::stats_t                 stats
);

    localparam int RttW   = cotr_pkg::RTT_W;
    localparam int SumW   = cotr_pkg::SUM_W;
    localparam int Depth  = cotr_pkg::RING_DEPTH;
    localparam int SlotW  = cotr_pkg::SLOT_W;
    localparam int CntW   = cotr_pkg::CNT_W;
    localparam int Levels = cotr_pkg::TREE_LEVELS;
    localparam int Nodes  = cotr_pkg::TREE_NODES;

    logic [RttW-1:0]  ring_reg [Depth];
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic [SlotW-1:0] oldest_reg;
    logic [SlotW-1:0] oldest_next;
    logic [SlotW-1:0] wr_slot;
    logic             full;

    logic [RttW-1:0] mn [Levels+1][Nodes];
    logic [RttW-1:0] mx [Levels+1][Nodes];
    logic [SumW-1:0] sm [Levels+1][Nodes];

    assign full = (count_reg == CntW'(Depth));

    always_comb
    begin
        if (full)
        begin
            wr_slot     = oldest_reg;
            count_next  = count_reg;
            oldest_next = (oldest_reg == SlotW'(Depth - 1)) ? '0 : oldest_reg + 1'b1;
        end
        else
        begin
            wr_slot     = count_reg[SlotW-1:0];
            count_next  = count_reg + 1'b1;
            oldest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            oldest_reg <= '0;
        end
        else if (advance)
        begin
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
        end
    end

    // ring payload, no reset: used only once every entry has been written
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Depth; i++)
        begin
            if (advance && wr_slot == SlotW'(i))
            begin
                ring_reg[i] <= rtt;
            end
        end
    end

    // pairwise reduction; unused leaves are neutral for min, max and sum
    always_comb
    begin
        for (int n = 0; n < Nodes; n++)
        begin
            if (n == 0)
            begin
                mn[0][n] = rtt;
                mx[0][n] = rtt;
                sm[0][n] = SumW'(rtt);
            end
            else if (n <= Depth)
            begin
                mn[0][n] = ring_reg[n-1];
                mx[0][n] = ring_reg[n-1];
                sm[0][n] = SumW'(ring_reg[n-1]);
            end
            else
            begin
                mn[0][n] = cotr_pkg::RTT_MAX;
                mx[0][n] = '0;
                sm[0][n] = '0;
            end
        end
        for (int l = 1; l <= Levels; l++)
        begin
            for (int n = 0; n < Nodes; n++)
            begin
                if (n < (Nodes >> l))
                begin
                    mn[l][n] = (mn[l-1][2*n+1] < mn[l-1][2*n]) ? mn[l-1][2*n+1] : mn[l-1][2*n];
                    mx[l][n] = (mx[l-1][2*n+1] > mx[l-1][2*n]) ? mx[l-1][2*n+1] : mx[l-1][2*n];
                    sm[l][n] = sm[l-1][2*n] + sm[l-1][2*n+1];
                end
                else
                begin
                    mn[l][n] = cotr_pkg::RTT_MAX;
                    mx[l][n] = '0;
                    sm[l][n] = '0;
                end
            end
        end
    end

    assign stats.sum  = sm[Levels][0];
    assign stats.lo   = mn[Levels][0];
    assign stats.hi   = mx[Levels][0];
    assign stats.full = full;

endmodule

`default_nettype wire

[sv/cotr_trim.sv]
// trimmed mean: window sum less min and max, divided by the trimmed count
// depends on cotr_pkg; division is a multiply by a constant reciprocal
`default_nettype none

module cotr_trim (
    input  wire cotr_pkg::stats_t              stats,
    output logic [cotr_pkg::RTT_W-1:0]         mean
);

    localparam int RttW  = cotr_pkg::RTT_W;
    localparam int SumW  = cotr_pkg::SUM_W;
    localparam int ProdW = cotr_pkg::PROD_W;

    logic [SumW-1:0]  trimmed;
    logic [ProdW-1:0] product;

    always_comb
    begin
        trimmed = stats.sum - SumW'(stats.lo) - SumW'(stats.hi);
        product = ProdW'(trimmed) * ProdW'(cotr_pkg::RECIP);
        mean    = product[cotr_pkg::DIV_SHIFT +: RttW];
    end

endmodule

`default_nettype wire

[sv/cotr_offset.sv]
// picks the used rtt and forms the clock offset of one response beat
// depends on cotr_pkg
`default_nettype none

module cotr_offset (
    input  wire [cotr_pkg::OFFSET_W-1:0]  diff,
    input  wire [cotr_pkg::RTT_W-1:0]     rtt,
    input  wire [cotr_pkg::RTT_W-1:0]     mean,
    input  wire                           full,
    output cotr_pkg::rsp_t                rsp
);

    localparam int OffW = cotr_pkg::OFFSET_W;
    localparam int RttW = cotr_pkg::RTT_W;

    logic [RttW-1:0] used;
    logic [OffW-1:0] offset;

    always_comb
    begin
        used   = full ? mean : rtt;
        // wraps modulo 2^41
        offset = diff - OffW'(used >> 1);
        rsp.clock_offset = offset;
        rsp.used_rtt     = used;
        rsp.window_full  = full;
    end

endmodule

`default_nettype wire

[sv/cotr_checker.sv]
// port-level checks for clock_offset_trimmed_rtt, bound to the top level
// depends on cotr_pkg
`default_nettype none

module cotr_checker (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    input  wire                  req_stall,
    input  wire                  rsp_valid,
    input  wire                  rsp_stall,
    input  wire cotr_pkg::rsp_t  rsp
);

    localparam int Depth = cotr_pkg::RING_DEPTH;
    localparam int CntW  = cotr_pkg::CNT_W;
    localparam int PipeD = cotr_pkg::PIPE_DEPTH;
    localparam int OutW  = $clog2(PipeD + 2);

    logic            req_beat;
    logic            rsp_beat;
    logic [OutW-1:0] outstanding_reg;
    logic [CntW-1:0] rsp_count_reg;

    assign req_beat = req_valid && !req_stall;
    assign rsp_beat = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            rsp_count_reg   <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + OutW'(req_beat) - OutW'(rsp_beat);
            if (rsp_beat && rsp_count_reg != CntW'(Depth))
            begin
                rsp_count_reg <= rsp_count_reg + 1'b1;
            end
        end
    end

    // a held response does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed under stall");

    // every response beat belongs to an accepted request still in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != '0)
        else $error("response without an outstanding request");

    // the pipeline never holds more beats than it has registers
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OutW'(PipeD))
        else $error("more requests in flight than pipeline registers");

    // the first ring-depth responses use the raw rtt
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_count_reg != CntW'(Depth) |-> !rsp.window_full)
        else $error("full window reported before the ring filled");

    // after that, every response uses the trimmed mean
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_count_reg == CntW'(Depth) |-> rsp.window_full)
        else $error("raw rtt used after the ring filled");

endmodule

bind clock_offset_trimmed_rtt cotr_checker u_cotr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
